@@ hw/rtl/hdp_pkg.sv @@
// shared types, constants and helper functions of the http date parser
`default_nettype none
package hdp_pkg;

  typedef enum logic [3:0] {
    PH_DAY_SEEK   = 4'd0,
    PH_DAY_DIG    = 4'd1,
    PH_MONTH_SEEK = 4'd2,
    PH_YEAR_SEEK  = 4'd3,
    PH_YEAR_DIG   = 4'd4,
    PH_SPACE_SEEK = 4'd5,
    PH_HOUR       = 4'd6,
    PH_MIN        = 4'd7,
    PH_SEC        = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    NM_SPACE = 2'd0,
    NM_SIGN  = 2'd1,
    NM_DIGIT = 2'd2,
    NM_DONE  = 2'd3
  } num_mode_t;

  typedef struct packed {
    phase_t             phase;
    logic [15:0]        accum;
    logic               neg;
    num_mode_t          num_mode;
    logic [14:0]        day;
    logic [23:0]        mletters;
    logic [1:0]         mcount;
    logic [14:0]        year;
    logic signed [15:0] hour;
    logic signed [15:0] minute;
  } scan_t;

  // what the result stage needs from the finished string
  typedef struct packed {
    logic               ok;
    logic [14:0]        day;
    logic [23:0]        mletters;
    logic [14:0]        year;
    logic signed [15:0] hour;
    logic signed [15:0] minute;
    logic signed [15:0] second;
    logic [23:0]        wletters;
  } snap_t;

  localparam scan_t SCAN_CLEAR = '{phase: PH_DAY_SEEK, num_mode: NM_SPACE, default: '0};

  localparam logic [15:0] NUM_CAP    = 16'd32768;
  localparam logic [14:0] YEAR_MIN   = 15'd1990;
  localparam logic [14:0] YEAR_PIVOT = 15'd40;
  localparam logic [14:0] CENT_20    = 15'd2000;
  localparam logic [14:0] CENT_19    = 15'd1900;
  localparam logic [14:0] TWO_DIGIT  = 15'd100;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) ? c - 8'd32 : c;
  endfunction

  function automatic logic [15:0] acc_push(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] v;
    v = {4'b0, acc} * 20'd10 + {16'b0, c[3:0]};
    return (v > {4'b0, NUM_CAP}) ? NUM_CAP : v[15:0];
  endfunction

  function automatic logic [14:0] cap15(input logic [15:0] v);
    return v[15] ? 15'h7fff : v[14:0];
  endfunction

  function automatic logic signed [15:0] num_value(input scan_t s);
    if (s.neg) return 16'(16'd0 - s.accum);
    return $signed({1'b0, cap15(s.accum)});
  endfunction

  // days before each month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      4'd11:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/http_date_string_parser.sv @@
// top level of the http date parser: character front end, two scan lanes, result pipe
`default_nettype none
// Takes one character of an HTTP date string per word and returns one decoded
// result word for each input word marked last. A new character is taken every
// cycle while in_ready is high; the result passes through a snapshot register,
// then the decode into the output register, and the output register lets the
// input keep flowing while a result waits to be taken. A zero byte ends the
// string; bytes after it are ignored until the last marker, after which all
// parser state starts over for the next string.
module http_date_string_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic signed [15:0] out_second,
  output logic signed [15:0] out_minute,
  output logic signed [15:0] out_hour,
  output logic [14:0]        out_month_day,
  output logic [3:0]         out_month_index,
  output logic [14:0]        out_years_since_1900,
  output logic [2:0]         out_weekday,
  output logic signed [16:0] out_year_day
);
  import hdp_pkg::*;

  logic [23:0] wlet_r, wlet_nxt;
  logic [1:0]  llc_r, llc_nxt;
  logic        comma_r, comma_nxt;
  logic        ended_r, ended_nxt;
  scan_t       scan0_r, scan0_nxt, scan1_r, scan1_nxt;
  scan_t       s0_step, s1_step, s1_base, sel;
  snap_t       snap_r, snap_nxt;
  logic        s1v_r, s1v_nxt;
  logic        outv_r;
  logic        adv_out, accept;
  logic        active;

  logic               r_valid_res;
  logic signed [15:0] r_second, r_minute, r_hour;
  logic [14:0]        r_month_day, r_years;
  logic [3:0]         r_month_index;
  logic [2:0]         r_weekday;
  logic signed [16:0] r_year_day;

  assign adv_out  = !outv_r || out_ready;
  assign in_ready = !s1v_r || adv_out;
  assign accept   = in_valid && in_ready;
  assign active   = !ended_r && in_char_byte != 8'd0;

  assign s1_base = (in_char_byte == 8'h2c && !comma_r) ? SCAN_CLEAR : scan1_r;

  hdp_scan u_scan0 (.cur(scan0_r), .c(in_char_byte), .nxt(s0_step));
  hdp_scan u_scan1 (.cur(s1_base), .c(in_char_byte), .nxt(s1_step));

  always_comb begin
    wlet_nxt  = wlet_r;
    llc_nxt   = llc_r;
    comma_nxt = comma_r;
    ended_nxt = ended_r;
    scan0_nxt = scan0_r;
    scan1_nxt = scan1_r;
    if (!ended_r && in_char_byte == 8'd0) ended_nxt = 1'b1;
    if (active) begin
      if (!(llc_r == 2'd0 && in_char_byte == 8'h20) && llc_r != 2'd3) begin
        wlet_nxt = wlet_r | ({16'b0, to_upper(in_char_byte)} << {llc_r, 3'b000});
        llc_nxt  = llc_r + 2'd1;
      end
      if (in_char_byte == 8'h2c) comma_nxt = 1'b1;
      scan0_nxt = s0_step;
      scan1_nxt = comma_nxt ? s1_step : scan1_r;
    end
    sel = comma_nxt ? scan1_nxt : scan0_nxt;
    snap_nxt.ok       = (sel.phase == PH_SEC);
    snap_nxt.day      = sel.day;
    snap_nxt.mletters = sel.mletters;
    snap_nxt.year     = sel.year;
    snap_nxt.hour     = sel.hour;
    snap_nxt.minute   = sel.minute;
    snap_nxt.second   = num_value(sel);
    snap_nxt.wletters = wlet_nxt;
    // snapshot stage: loads on a last word, drains into the output register
    s1v_nxt = s1v_r && !adv_out;
    if (accept && in_last) s1v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlet_r  <= '0;
      llc_r   <= '0;
      comma_r <= 1'b0;
      ended_r <= 1'b0;
      scan0_r <= SCAN_CLEAR;
      scan1_r <= SCAN_CLEAR;
      s1v_r   <= 1'b0;
    end else begin
      s1v_r <= s1v_nxt;
      if (accept) begin
        if (in_last) begin
          wlet_r  <= '0;
          llc_r   <= '0;
          comma_r <= 1'b0;
          ended_r <= 1'b0;
          scan0_r <= SCAN_CLEAR;
          scan1_r <= SCAN_CLEAR;
        end else begin
          wlet_r  <= wlet_nxt;
          llc_r   <= llc_nxt;
          comma_r <= comma_nxt;
          ended_r <= ended_nxt;
          scan0_r <= scan0_nxt;
          scan1_r <= scan1_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) snap_r <= snap_nxt;
  end

  hdp_result u_result (
    .snap             (snap_r),
    .valid_res        (r_valid_res),
    .second           (r_second),
    .minute           (r_minute),
    .hour             (r_hour),
    .month_day        (r_month_day),
    .month_index      (r_month_index),
    .years_since_1900 (r_years),
    .weekday          (r_weekday),
    .year_day         (r_year_day)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (adv_out) begin
      outv_r <= s1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1v_r) begin
      out_valid_res        <= r_valid_res;
      out_second           <= r_second;
      out_minute           <= r_minute;
      out_hour             <= r_hour;
      out_month_day        <= r_month_day;
      out_month_index      <= r_month_index;
      out_years_since_1900 <= r_years;
      out_weekday          <= r_weekday;
      out_year_day         <= r_year_day;
    end
  end

  assign out_valid = outv_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1v_r |-> in_ready) else $error("input stalled with empty snapshot stage");

  a_snap_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1v_r && !outv_r) |=> outv_r) else $error("snapshot did not reach output");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && !out_valid_res) |-> (out_second == 16'sd0 && out_years_since_1900 == 15'd0
      && out_year_day == 17'sd0)) else $error("invalid result carries data");

endmodule
`default_nettype wire

@@ hw/rtl/hdp_scan.sv @@
// one scan lane: next state of the field scanner for one character
`default_nettype none
module hdp_scan (
  input  hdp_pkg::scan_t cur,
  input  logic [7:0]     c,
  output hdp_pkg::scan_t nxt
);
  import hdp_pkg::*;

  always_comb begin
    nxt = cur;
    if (cur.mcount != 2'd0 && cur.mcount != 2'd3) begin
      nxt.mletters = cur.mletters | ({16'b0, to_upper(c)} << {cur.mcount, 3'b000});
      nxt.mcount   = cur.mcount + 2'd1;
    end
    case (cur.phase)
      PH_DAY_SEEK: begin
        if (is_digit(c)) begin
          nxt.accum = acc_push(16'd0, c);
          nxt.phase = PH_DAY_DIG;
        end
      end
      PH_DAY_DIG: begin
        if (is_digit(c)) begin
          nxt.accum = acc_push(cur.accum, c);
        end else begin
          nxt.day = cap15(cur.accum);
          if (is_alpha(c)) begin
            nxt.mletters = {16'b0, to_upper(c)};
            nxt.mcount   = 2'd1;
            nxt.phase    = PH_YEAR_SEEK;
          end else begin
            nxt.phase = PH_MONTH_SEEK;
          end
        end
      end
      PH_MONTH_SEEK: begin
        if (is_alpha(c)) begin
          nxt.mletters = {16'b0, to_upper(c)};
          nxt.mcount   = 2'd1;
          nxt.phase    = PH_YEAR_SEEK;
        end
      end
      PH_YEAR_SEEK: begin
        if (is_digit(c)) begin
          nxt.accum = acc_push(16'd0, c);
          nxt.phase = PH_YEAR_DIG;
        end
      end
      PH_YEAR_DIG, PH_SPACE_SEEK: begin
        if (cur.phase == PH_YEAR_DIG && is_digit(c)) begin
          nxt.accum = acc_push(cur.accum, c);
        end else begin
          if (cur.phase == PH_YEAR_DIG) nxt.year = cap15(cur.accum);
          if (c == 8'h20) begin
            nxt.accum    = '0;
            nxt.neg      = 1'b0;
            nxt.num_mode = NM_SPACE;
            nxt.phase    = PH_HOUR;
          end else begin
            nxt.phase = PH_SPACE_SEEK;
          end
        end
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (c == 8'h3a && cur.phase != PH_SEC) begin
          if (cur.phase == PH_HOUR) nxt.hour = num_value(cur);
          else nxt.minute = num_value(cur);
          nxt.accum    = '0;
          nxt.neg      = 1'b0;
          nxt.num_mode = NM_SPACE;
          nxt.phase    = (cur.phase == PH_HOUR) ? PH_MIN : PH_SEC;
        end else begin
          // decimal number reader
          case (cur.num_mode)
            NM_SPACE: begin
              if (is_space(c)) begin
                nxt.num_mode = NM_SPACE;
              end else if (c == 8'h2b || c == 8'h2d) begin
                nxt.neg      = (c == 8'h2d);
                nxt.num_mode = NM_SIGN;
              end else if (is_digit(c)) begin
                nxt.accum    = acc_push(16'd0, c);
                nxt.num_mode = NM_DIGIT;
              end else begin
                nxt.num_mode = NM_DONE;
              end
            end
            NM_SIGN, NM_DIGIT: begin
              if (is_digit(c)) begin
                nxt.accum    = acc_push(cur.accum, c);
                nxt.num_mode = NM_DIGIT;
              end else begin
                nxt.num_mode = NM_DONE;
              end
            end
            default: nxt.num_mode = cur.num_mode;
          endcase
        end
      end
      default: nxt.phase = cur.phase;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/hdp_result.sv @@
// result decode: year expansion, leap test, month, weekday and year day
`default_nettype none
module hdp_result (
  input  hdp_pkg::snap_t      snap,
  output logic                valid_res,
  output logic signed [15:0]  second,
  output logic signed [15:0]  minute,
  output logic signed [15:0]  hour,
  output logic [14:0]         month_day,
  output logic [3:0]          month_index,
  output logic [14:0]         years_since_1900,
  output logic [2:0]          weekday,
  output logic signed [16:0]  year_day
);
  import hdp_pkg::*;

  logic [14:0] yr;
  logic [27:0] prod;
  logic [10:0] q;
  logic [14:0] q25;
  logic        div25;
  logic        leap;
  logic [3:0]  mon;
  logic [2:0]  wd;
  logic [7:0]  ma, mb, mc, wa, wb;

  always_comb begin
    if (snap.year < YEAR_PIVOT) yr = snap.year + CENT_20;
    else if (snap.year < TWO_DIGIT) yr = snap.year + CENT_19;
    else yr = snap.year;
    if (yr < YEAR_MIN) yr = YEAR_MIN;
  end

  // divisible by 25 through a reciprocal multiply, exact for 15-bit years
  assign prod  = {13'b0, yr} * 28'd5243;
  assign q     = prod[27:17];
  assign q25   = 15'({q, 4'b0}) + 15'({q, 3'b0}) + {4'b0, q};
  assign div25 = (q25 == yr);
  assign leap  = (yr[1:0] == 2'b00) && (!div25 || yr[3:0] == 4'b0000);

  assign ma = snap.mletters[7:0];
  assign mb = snap.mletters[15:8];
  assign mc = snap.mletters[23:16];
  assign wa = snap.wletters[7:0];
  assign wb = snap.wletters[15:8];

  always_comb begin
    if (ma == "J" && mb == "A") mon = 4'd0;
    else if (ma == "F") mon = 4'd1;
    else if (ma == "M" && mc == "R") mon = 4'd2;
    else if (ma == "A" && mb == "P") mon = 4'd3;
    else if (ma == "M") mon = 4'd4;
    else if (ma == "J" && mc == "N") mon = 4'd5;
    else if (ma == "J") mon = 4'd6;
    else if (ma == "A") mon = 4'd7;
    else if (ma == "S") mon = 4'd8;
    else if (ma == "O") mon = 4'd9;
    else if (ma == "N") mon = 4'd10;
    else if (ma == "D") mon = 4'd11;
    else mon = 4'd6;
  end

  always_comb begin
    if (wa == "M") wd = 3'd0;
    else if (wa == "T" && wb == "U") wd = 3'd1;
    else if (wa == "W") wd = 3'd2;
    else if (wa == "T") wd = 3'd3;
    else if (wa == "F") wd = 3'd4;
    else if (wa == "S" && wb == "A") wd = 3'd5;
    else if (wa == "S") wd = 3'd6;
    else wd = 3'd0;
  end

  always_comb begin
    valid_res        = snap.ok;
    second           = '0;
    minute           = '0;
    hour             = '0;
    month_day        = '0;
    month_index      = '0;
    years_since_1900 = '0;
    weekday          = '0;
    year_day         = '0;
    if (snap.ok) begin
      second           = snap.second;
      minute           = snap.minute;
      hour             = snap.hour;
      month_day        = snap.day;
      month_index      = mon;
      years_since_1900 = yr - CENT_19;
      weekday          = wd;
      year_day         = $signed({2'b0, snap.day}) - 17'sd1
                       + $signed({8'b0, days_before(mon)})
                       + $signed({16'b0, leap && mon > 4'd1});
    end
  end

endmodule
`default_nettype wire
